// ----- sv/dbp_pkg.sv -----
// Shared types and constants for the debounce and pulse output block.
`default_nettype none

package dbp_pkg;

    // Request action codes
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_SAMPLE = 2'd1;
    localparam logic [1:0] ACT_PULSE  = 2'd2;
    localparam logic [1:0] ACT_TOGGLE = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_ACTIVE_LEVEL  = 3'd0;
    localparam logic [2:0] CFG_PULSE_MS      = 3'd1;
    localparam logic [2:0] CFG_LATCH_MS      = 3'd2;
    localparam logic [2:0] CFG_DOORBELL_LINK = 3'd3;
    localparam logic [2:0] CFG_IN0_BIT_INDEX = 3'd4;
    localparam logic [2:0] CFG_IN1_BIT_INDEX = 3'd5;

    // Configuration reset values
    localparam logic [15:0] PULSE_MS_DEFAULT = 16'd1500;
    localparam logic [23:0] LATCH_MS_DEFAULT = 24'd30000;
    localparam logic [7:0]  SAMPLE_INIT      = 8'hFF;

    // Per-request control for one input channel
    typedef struct packed {
        logic step;      // a request is being applied
        logic sample;    // request is an input sample
        logic qualify;   // sample read ok and matches the previous good sample
    } in_ctl_t;

    // Per-request control for one output channel
    typedef struct packed {
        logic step;
        logic pulse;
        logic toggle;
    } out_ctl_t;

    // State of one input channel after a request
    typedef struct packed {
        logic        active;
        logic        rose;
        logic        fell;
        logic [15:0] count;
        logic [31:0] held;
    } in_stat_t;

    // State of one output channel after a request
    typedef struct packed {
        logic        sinking;
        logic        latched;
        logic [15:0] pulses;
    } out_stat_t;

endpackage

`default_nettype wire

// ----- sv/dbp_in_unit.sv -----
// One debounced input channel: activation state, count, edge time and hold time.
`default_nettype none

module dbp_in_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dbp_pkg::in_ctl_t   ctl,
    input  wire logic               bit_value,
    input  wire logic               active_level,
    input  wire logic [31:0]        time_now,
    output dbp_pkg::in_stat_t       stat_next
);

    logic        active_reg, active_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] edge_reg, edge_next;
    logic [31:0] held_reg, held_next;
    logic        level_match;
    logic        rose, fell;

    assign level_match = (bit_value == active_level);

    always_comb
    begin
        active_next = active_reg;
        count_next  = count_reg;
        edge_next   = edge_reg;
        held_next   = held_reg;
        rose        = 1'b0;
        fell        = 1'b0;
        if (ctl.qualify && (level_match != active_reg))
        begin
            active_next = level_match;
            if (level_match)
            begin
                count_next = count_reg + 16'd1;
                edge_next  = time_now;
                held_next  = '0;
                rose       = 1'b1;
            end
            else
            begin
                held_next = time_now - edge_reg;
                fell      = 1'b1;
            end
        end
        // live hold time on every sample while the input is active
        if (ctl.sample && active_next)
        begin
            held_next = time_now - edge_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            count_reg  <= '0;
            edge_reg   <= '0;
            held_reg   <= '0;
        end
        else if (ctl.step)
        begin
            active_reg <= active_next;
            count_reg  <= count_next;
            edge_reg   <= edge_next;
            held_reg   <= held_next;
        end
    end

    assign stat_next.active = active_next;
    assign stat_next.rose   = rose;
    assign stat_next.fell   = fell;
    assign stat_next.count  = count_next;
    assign stat_next.held   = held_next;

endmodule

`default_nettype wire

// ----- sv/dbp_out_unit.sv -----
// One open-drain output channel: bounded pulse, latch toggle and auto-off deadline.
`default_nettype none

module dbp_out_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dbp_pkg::out_ctl_t  ctl,
    input  wire logic [31:0]        time_now,
    input  wire logic [31:0]        time_next,
    input  wire logic [15:0]        pulse_ms,
    input  wire logic [23:0]        latch_ms,
    output dbp_pkg::out_stat_t      stat_next
);

    logic        sinking_reg, sinking_next;
    logic        latched_reg, latched_next;
    logic        armed_reg, armed_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [15:0] pulses_reg, pulses_next;
    logic [31:0] slack;

    always_comb
    begin
        sinking_next  = sinking_reg;
        latched_next  = latched_reg;
        armed_next    = armed_reg;
        deadline_next = deadline_reg;
        pulses_next   = pulses_reg;
        if (ctl.pulse)
        begin
            latched_next  = 1'b0;
            pulses_next   = pulses_reg + 16'd1;
            deadline_next = time_now + {16'd0, pulse_ms};
            armed_next    = 1'b1;
            sinking_next  = 1'b1;
        end
        else if (ctl.toggle)
        begin
            if (sinking_reg)
            begin
                latched_next = 1'b0;
                armed_next   = 1'b0;
                sinking_next = 1'b0;
            end
            else
            begin
                latched_next  = 1'b1;
                deadline_next = time_now + {8'd0, latch_ms};
                armed_next    = 1'b1;
                sinking_next  = 1'b1;
            end
        end
        // release once the deadline is reached (wrapped compare)
        slack = time_next - deadline_next;
        if (sinking_next && armed_next && !slack[31])
        begin
            latched_next = 1'b0;
            armed_next   = 1'b0;
            sinking_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sinking_reg  <= 1'b0;
            latched_reg  <= 1'b0;
            armed_reg    <= 1'b0;
            deadline_reg <= '0;
            pulses_reg   <= '0;
        end
        else if (ctl.step)
        begin
            sinking_reg  <= sinking_next;
            latched_reg  <= latched_next;
            armed_reg    <= armed_next;
            deadline_reg <= deadline_next;
            pulses_reg   <= pulses_next;
        end
    end

    assign stat_next.sinking = sinking_next;
    assign stat_next.latched = latched_next;
    assign stat_next.pulses  = pulses_next;

endmodule

`default_nettype wire

// ----- sv/isolated_io_debounce_pulse.sv -----
// Top level: request register, shared time base, input and output channels, result register.
// Path: a request accepted into the request register moves on into the result register,
//   whose outputs drive the result ports, when the result register is free or being taken.
// Throughput: one request per cycle while out_stall is low; the request register and the result
//   register each hold one request, so a stalled result still lets one more in.
// Reset (rst_n low, asynchronous): time and all channel state clear, previous
//   sample goes to all ones, configuration returns to its defaults.
`default_nettype none

module isolated_io_debounce_pulse #(
    parameter int CHANNELS = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic        channel,
    input  wire logic [7:0]  raw_inputs,
    input  wire logic        read_ok,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       in_active,
    output logic [1:0]       in_rose,
    output logic [1:0]       in_fell,
    output logic [15:0]      in0_count,
    output logic [15:0]      in1_count,
    output logic [31:0]      in0_held_ms,
    output logic [31:0]      in1_held_ms,
    output logic [1:0]       out_on,
    output logic [1:0]       out_latched,
    output logic [15:0]      out0_pulses,
    output logic [15:0]      out1_pulses,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers; always ready; the user must write them only while idle (not enforced).
    // ------------------------------------------------------------------
    logic        active_level_reg;
    logic [15:0] pulse_ms_reg;
    logic [23:0] latch_ms_reg;
    logic        doorbell_link_reg;
    logic [2:0]  in0_bit_index_reg;
    logic [2:0]  in1_bit_index_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg  <= 1'b0;
            pulse_ms_reg      <= dbp_pkg::PULSE_MS_DEFAULT;
            latch_ms_reg      <= dbp_pkg::LATCH_MS_DEFAULT;
            doorbell_link_reg <= 1'b1;
            in0_bit_index_reg <= 3'd0;
            in1_bit_index_reg <= 3'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dbp_pkg::CFG_ACTIVE_LEVEL:  active_level_reg  <= cfg_data[0];
                dbp_pkg::CFG_PULSE_MS:      pulse_ms_reg      <= cfg_data[15:0];
                dbp_pkg::CFG_LATCH_MS:      latch_ms_reg      <= cfg_data;
                dbp_pkg::CFG_DOORBELL_LINK: doorbell_link_reg <= cfg_data[0];
                dbp_pkg::CFG_IN0_BIT_INDEX: in0_bit_index_reg <= cfg_data[2:0];
                dbp_pkg::CFG_IN1_BIT_INDEX: in1_bit_index_reg <= cfg_data[2:0];
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request register and handshake.
    // Advance the held request whenever the result register is free or
    // being taken; accept a new request when none is held or the held one moves on.
    // ------------------------------------------------------------------
    logic        req_valid_reg;
    logic [1:0]  action_reg;
    logic        channel_reg;
    logic [7:0]  raw_reg;
    logic        read_ok_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        accept;

    assign advance  = req_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = req_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            req_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            req_valid_reg <= 1'b0;
        end
    end

    // payload: hold until the next accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg  <= action;
            channel_reg <= channel;
            raw_reg     <= raw_inputs;
            read_ok_reg <= read_ok;
        end
    end

    // ------------------------------------------------------------------
    // Decode the held request.
    // ------------------------------------------------------------------
    logic is_tick, is_sample, is_pulse, is_toggle;

    always_comb
    begin
        is_tick   = 1'b0;
        is_sample = 1'b0;
        is_pulse  = 1'b0;
        is_toggle = 1'b0;
        case (action_reg)
            dbp_pkg::ACT_TICK:   is_tick   = 1'b1;
            dbp_pkg::ACT_SAMPLE: is_sample = 1'b1;
            dbp_pkg::ACT_PULSE:  is_pulse  = 1'b1;
            dbp_pkg::ACT_TOGGLE: is_toggle = 1'b1;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared time base and sample agreement filter.
    // ------------------------------------------------------------------
    logic [31:0] time_reg, time_next;
    logic [7:0]  prev_sample_reg;
    logic        sample_good;
    logic        qualify;

    assign time_next   = is_tick ? time_reg + 32'd1 : time_reg;
    assign sample_good = is_sample && read_ok_reg;
    // a good read counts only when it matches the previous good read
    assign qualify     = sample_good && (raw_reg == prev_sample_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg        <= '0;
            prev_sample_reg <= dbp_pkg::SAMPLE_INIT;
        end
        else if (advance)
        begin
            time_reg <= time_next;
            if (sample_good)
            begin
                prev_sample_reg <= raw_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Channels.
    // ------------------------------------------------------------------
    dbp_pkg::in_ctl_t  in_ctl;
    dbp_pkg::in_stat_t in_stat [CHANNELS];
    dbp_pkg::out_stat_t out_stat [CHANNELS];
    logic [CHANNELS-1:0] active_vec, rose_vec, fell_vec, on_vec, latched_vec;

    assign in_ctl.step    = advance;
    assign in_ctl.sample  = is_sample;
    assign in_ctl.qualify = qualify;

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_chan
        logic [2:0]        bit_sel;
        logic              wants_doorbell;
        dbp_pkg::out_ctl_t out_ctl;

        // inputs past the second take a fixed bit position
        if (c == 0)
        begin : g_sel0
            assign bit_sel        = in0_bit_index_reg;
            assign wants_doorbell = doorbell_link_reg && in_stat[0].rose;
        end
        else if (c == 1)
        begin : g_sel1
            assign bit_sel        = in1_bit_index_reg;
            assign wants_doorbell = 1'b0;
        end
        else
        begin : g_selx
            assign bit_sel        = 3'(c % 8);
            assign wants_doorbell = 1'b0;
        end

        dbp_in_unit u_in (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (in_ctl),
            .bit_value    (raw_reg[bit_sel]),
            .active_level (active_level_reg),
            .time_now     (time_reg),
            .stat_next    (in_stat[c])
        );

        // only the first two outputs are reachable by a request
        assign out_ctl.step   = advance;
        assign out_ctl.pulse  = (is_pulse && ({31'd0, channel_reg} == 32'(c)))
                                || wants_doorbell;
        assign out_ctl.toggle = is_toggle && ({31'd0, channel_reg} == 32'(c));

        dbp_out_unit u_out (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (out_ctl),
            .time_now  (time_reg),
            .time_next (time_next),
            .pulse_ms  (pulse_ms_reg),
            .latch_ms  (latch_ms_reg),
            .stat_next (out_stat[c])
        );

        assign active_vec[c]  = in_stat[c].active;
        assign rose_vec[c]    = in_stat[c].rose;
        assign fell_vec[c]    = in_stat[c].fell;
        assign on_vec[c]      = out_stat[c].sinking;
        assign latched_vec[c] = out_stat[c].latched;
    end

    // Second channel's counters read as zero when only one channel exists.
    logic [15:0] in1_count_next, out1_pulses_next;
    logic [31:0] in1_held_next;

    if (CHANNELS > 1)
    begin : g_second
        assign in1_count_next   = in_stat[CHANNELS > 1 ? 1 : 0].count;
        assign in1_held_next    = in_stat[CHANNELS > 1 ? 1 : 0].held;
        assign out1_pulses_next = out_stat[CHANNELS > 1 ? 1 : 0].pulses;
    end
    else
    begin : g_single
        assign in1_count_next   = '0;
        assign in1_held_next    = '0;
        assign out1_pulses_next = '0;
    end

    // Pad the bitmaps so the low two bits exist at any channel count.
    logic [CHANNELS+1:0] active_pad, rose_pad, fell_pad, on_pad, latched_pad;

    assign active_pad  = {2'b00, active_vec};
    assign rose_pad    = {2'b00, rose_vec};
    assign fell_pad    = {2'b00, fell_vec};
    assign on_pad      = {2'b00, on_vec};
    assign latched_pad = {2'b00, latched_vec};

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_active   <= active_pad[1:0];
            in_rose     <= rose_pad[1:0];
            in_fell     <= fell_pad[1:0];
            in0_count   <= in_stat[0].count;
            in1_count   <= in1_count_next;
            in0_held_ms <= in_stat[0].held;
            in1_held_ms <= in1_held_next;
            out_on      <= on_pad[1:0];
            out_latched <= latched_pad[1:0];
            out0_pulses <= out_stat[0].pulses;
            out1_pulses <= out1_pulses_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- bench/io_status_checker.sv -----
// Checker: predicts every debounce/pulse result and compares it with the block's output.
`timescale 1ns / 1ps

module io_status_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  action,
    input  wire logic        channel,
    input  wire logic [7:0]  raw_inputs,
    input  wire logic        read_ok,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [1:0]  in_active,
    input  wire logic [1:0]  in_rose,
    input  wire logic [1:0]  in_fell,
    input  wire logic [15:0] in0_count,
    input  wire logic [15:0] in1_count,
    input  wire logic [31:0] in0_held_ms,
    input  wire logic [31:0] in1_held_ms,
    input  wire logic [1:0]  out_on,
    input  wire logic [1:0]  out_latched,
    input  wire logic [15:0] out0_pulses,
    input  wire logic [15:0] out1_pulses,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    output int               mismatches,
    output int               awaiting,
    output int               checked
);

    typedef struct packed {
        logic [1:0]  active;
        logic [1:0]  rose;
        logic [1:0]  fell;
        logic [15:0] count0;
        logic [15:0] count1;
        logic [31:0] held0;
        logic [31:0] held1;
        logic [1:0]  sinking;
        logic [1:0]  latched;
        logic [15:0] pulses0;
        logic [15:0] pulses1;
    } io_status_t;

    // Shadow state
    logic [31:0] now_ms;
    logic [7:0]  last_good;
    logic [1:0]  in_on;
    logic [15:0] act_count [2];
    logic [31:0] rise_at [2];
    logic [31:0] held [2];
    logic [1:0]  sink;
    logic [1:0]  latch;
    logic [1:0]  armed;
    logic [31:0] release_at [2];
    logic [15:0] pulses [2];

    // Shadow configuration
    logic        lvl;
    logic [15:0] pulse_len;
    logic [23:0] latch_len;
    logic        link;
    logic [2:0]  bit0;
    logic [2:0]  bit1;

    io_status_t pending_status [$];

    initial
    begin
        mismatches = 0;
        awaiting   = 0;
        checked    = 0;
    end

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        mismatches++;
    endtask

    task automatic note_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                      checked, name, got, want));
    endtask

    function automatic void restore_power_on();
        now_ms    = '0;
        last_good = dbp_pkg::SAMPLE_INIT;
        in_on     = '0;
        sink      = '0;
        latch     = '0;
        armed     = '0;
        for (int c = 0; c < 2; c++)
        begin
            act_count[c]  = '0;
            rise_at[c]    = '0;
            held[c]       = '0;
            release_at[c] = '0;
            pulses[c]     = '0;
        end
        lvl       = 1'b0;
        pulse_len = dbp_pkg::PULSE_MS_DEFAULT;
        latch_len = dbp_pkg::LATCH_MS_DEFAULT;
        link      = 1'b1;
        bit0      = 3'd0;
        bit1      = 3'd1;
    endfunction

    function automatic void fire_pulse(int c);
        latch[c]      = 1'b0;
        pulses[c]     = pulses[c] + 16'd1;
        release_at[c] = now_ms + 32'(pulse_len);
        armed[c]      = 1'b1;
        sink[c]       = 1'b1;
    endfunction

    function automatic void flip_latch(int c);
        if (sink[c])
        begin
            latch[c] = 1'b0;
            armed[c] = 1'b0;
            sink[c]  = 1'b0;
        end
        else
        begin
            latch[c]      = 1'b1;
            release_at[c] = now_ms + 32'(latch_len);
            armed[c]      = 1'b1;
            sink[c]       = 1'b1;
        end
    endfunction

    // Apply one request to the shadow state and return the status it leaves.
    function automatic io_status_t advance_io(logic [1:0] act, logic ch,
                                              logic [7:0] raw, logic ok);
        io_status_t  r;
        logic [1:0]  rose;
        logic [1:0]  fell;
        logic [2:0]  b;
        logic        lit;
        logic [31:0] diff;
        rose = '0;
        fell = '0;
        case (act)
            dbp_pkg::ACT_TICK:   now_ms = now_ms + 32'd1;
            dbp_pkg::ACT_SAMPLE:
            begin
                if (ok)
                begin
                    // only a byte that repeats the last good read qualifies
                    if (raw == last_good)
                    begin
                        for (int c = 0; c < 2; c++)
                        begin
                            b   = (c == 0) ? bit0 : bit1;
                            lit = (raw[b] == lvl);
                            if (lit != in_on[c])
                            begin
                                in_on[c] = lit;
                                if (lit)
                                begin
                                    act_count[c] = act_count[c] + 16'd1;
                                    rise_at[c]   = now_ms;
                                    held[c]      = '0;
                                    rose[c]      = 1'b1;
                                    if (c == 0 && link)
                                        fire_pulse(0);
                                end
                                else
                                begin
                                    held[c] = now_ms - rise_at[c];
                                    fell[c] = 1'b1;
                                end
                            end
                        end
                    end
                    last_good = raw;
                end
                for (int c = 0; c < 2; c++)
                    if (in_on[c])
                        held[c] = now_ms - rise_at[c];
            end
            dbp_pkg::ACT_PULSE:  fire_pulse(int'(ch));
            dbp_pkg::ACT_TOGGLE: flip_latch(int'(ch));
            default:    ;
        endcase

        // release any armed output whose deadline is reached
        for (int c = 0; c < 2; c++)
        begin
            diff = now_ms - release_at[c];
            if (sink[c] && armed[c] && !diff[31])
            begin
                latch[c] = 1'b0;
                armed[c] = 1'b0;
                sink[c]  = 1'b0;
            end
        end

        r.active  = in_on;
        r.rose    = rose;
        r.fell    = fell;
        r.count0  = act_count[0];
        r.count1  = act_count[1];
        r.held0   = held[0];
        r.held1   = held[1];
        r.sinking = sink;
        r.latched = latch;
        r.pulses0 = pulses[0];
        r.pulses1 = pulses[1];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        io_status_t want;
        if (!rst_n)
        begin
            restore_power_on();
            pending_status.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dbp_pkg::CFG_ACTIVE_LEVEL:  lvl       = cfg_data[0];
                    dbp_pkg::CFG_PULSE_MS:      pulse_len = cfg_data[15:0];
                    dbp_pkg::CFG_LATCH_MS:      latch_len = cfg_data;
                    dbp_pkg::CFG_DOORBELL_LINK: link      = cfg_data[0];
                    dbp_pkg::CFG_IN0_BIT_INDEX: bit0      = cfg_data[2:0];
                    dbp_pkg::CFG_IN1_BIT_INDEX: bit1      = cfg_data[2:0];
                    default:                    ;
                endcase
            end
            if (in_valid && !in_stall)
                pending_status.push_back(advance_io(action, channel, raw_inputs, read_ok));
            if (out_valid && !out_stall)
            begin
                if (pending_status.size() == 0)
                    report_mismatch("result with no request waiting");
                else
                begin
                    want = pending_status.pop_front();
                    note_field("in_active",   32'(in_active),   32'(want.active));
                    note_field("in_rose",     32'(in_rose),     32'(want.rose));
                    note_field("in_fell",     32'(in_fell),     32'(want.fell));
                    note_field("in0_count",   32'(in0_count),   32'(want.count0));
                    note_field("in1_count",   32'(in1_count),   32'(want.count1));
                    note_field("in0_held_ms", in0_held_ms,      want.held0);
                    note_field("in1_held_ms", in1_held_ms,      want.held1);
                    note_field("out_on",      32'(out_on),      32'(want.sinking));
                    note_field("out_latched", 32'(out_latched), 32'(want.latched));
                    note_field("out0_pulses", 32'(out0_pulses), 32'(want.pulses0));
                    note_field("out1_pulses", 32'(out1_pulses), 32'(want.pulses1));
                    checked++;
                end
            end
        end
        awaiting = pending_status.size();
    end

endmodule

// ----- bench/isolated_io_debounce_pulse_tb.sv -----
// Testbench top: drives requests and settings into the block and reports the verdict.
`timescale 1ns / 1ps

module isolated_io_debounce_pulse_tb;

    // Indexes past the last register: writes there must change nothing
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 165;
    localparam int LONG_HOLD    = 300;   // cycles of result hold-off for the pressure test
    localparam int DRAIN_CYCLES = 8;     // extra settle wait once every awaited result is back
    localparam int LIMIT_NS     = 3_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  action = dbp_pkg::ACT_TICK;
    logic        channel = 1'b0;
    logic [7:0]  raw_inputs = 8'h00;
    logic        read_ok = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  in_active;
    logic [1:0]  in_rose;
    logic [1:0]  in_fell;
    logic [15:0] in0_count;
    logic [15:0] in1_count;
    logic [31:0] in0_held_ms;
    logic [31:0] in1_held_ms;
    logic [1:0]  out_on;
    logic [1:0]  out_latched;
    logic [15:0] out0_pulses;
    logic [15:0] out1_pulses;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [23:0] cfg_data = 24'd0;

    int mismatches;
    int awaiting;
    int checked;

    // Idle and stall rates in percent, set per phase
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_request  = 1'b0;

    int kind_sent [4] = '{0, 0, 0, 0};
    int total_sent    = 0;

    isolated_io_debounce_pulse DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .channel     (channel),
        .raw_inputs  (raw_inputs),
        .read_ok     (read_ok),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .in_active   (in_active),
        .in_rose     (in_rose),
        .in_fell     (in_fell),
        .in0_count   (in0_count),
        .in1_count   (in1_count),
        .in0_held_ms (in0_held_ms),
        .in1_held_ms (in1_held_ms),
        .out_on      (out_on),
        .out_latched (out_latched),
        .out0_pulses (out0_pulses),
        .out1_pulses (out1_pulses),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    io_status_checker status_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .channel     (channel),
        .raw_inputs  (raw_inputs),
        .read_ok     (read_ok),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .in_active   (in_active),
        .in_rose     (in_rose),
        .in_fell     (in_fell),
        .in0_count   (in0_count),
        .in1_count   (in1_count),
        .in0_held_ms (in0_held_ms),
        .in1_held_ms (in1_held_ms),
        .out_on      (out_on),
        .out_latched (out_latched),
        .out0_pulses (out0_pulses),
        .out1_pulses (out1_pulses),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .awaiting    (awaiting),
        .checked     (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs on a handshake
    initial
    begin
        #(LIMIT_NS);
        $display("Timeout after %0d ns with %0d results still awaited", LIMIT_NS, awaiting);
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: stall at the phase rate, or hold off for a long stretch on request.
    // The long hold lets the result register and the request register fill up so
    // the block has to push back on the request side.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
        end
    end

    // Offer one request and hold it until the block takes it. Valid is only
    // dropped for an idle gap, never in the same step as it is raised again.
    task automatic send_request(logic [1:0] act, logic ch, logic [7:0] raw, logic ok);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        action     <= act;
        channel    <= ch;
        raw_inputs <= raw;
        read_ok    <= ok;
        do
            @(posedge clk);
        while (in_stall);
        kind_sent[act]++;
        total_sent++;
    endtask

    // Stop offering, wait until every result is back, then let the pipe settle.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (awaiting != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Present one register write; valid is left high so writes can go back to back.
    task automatic cfg_write(logic [2:0] idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic apply_settings(logic lvl, logic [15:0] pulse_len, logic [23:0] latch_len,
                                  logic link, logic [2:0] bit0, logic [2:0] bit1);
        cfg_write(dbp_pkg::CFG_ACTIVE_LEVEL,  24'(lvl));
        cfg_write(dbp_pkg::CFG_PULSE_MS,      24'(pulse_len));
        cfg_write(dbp_pkg::CFG_LATCH_MS,      latch_len);
        cfg_write(dbp_pkg::CFG_DOORBELL_LINK, 24'(link));
        cfg_write(dbp_pkg::CFG_IN0_BIT_INDEX, 24'(bit0));
        cfg_write(dbp_pkg::CFG_IN1_BIT_INDEX, 24'(bit1));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Directed opening under reset settings: first qualified read, edges in both
    // directions, doorbell pulse, failed read, pulse and latch toggling on both
    // outputs, and a doorbell pulse landing on a latched output.
    task automatic run_directed();
        send_request(dbp_pkg::ACT_SAMPLE, 1'b0, 8'hFF, 1'b1);  // matches power-on byte
        send_request(dbp_pkg::ACT_SAMPLE, 1'b0, 8'h00, 1'b1);  // first read of a new byte
        send_request(dbp_pkg::ACT_SAMPLE, 1'b1, 8'h00, 1'b1);  // repeat: both rise, doorbell
        send_request(dbp_pkg::ACT_TICK,   1'b0, 8'h00, 1'b0);
        send_request(dbp_pkg::ACT_TICK,   1'b1, 8'hFF, 1'b1);
        send_request(dbp_pkg::ACT_SAMPLE, 1'b0, 8'h55, 1'b0);  // failed read: ignored
        send_request(dbp_pkg::ACT_SAMPLE, 1'b0, 8'h00, 1'b1);  // still matches last good byte
        send_request(dbp_pkg::ACT_PULSE,  1'b1, 8'hAA, 1'b0);
        send_request(dbp_pkg::ACT_TOGGLE, 1'b0, 8'h00, 1'b0);  // sinking: toggle releases
        send_request(dbp_pkg::ACT_TOGGLE, 1'b0, 8'h00, 1'b0);  // released: toggle latches
        send_request(dbp_pkg::ACT_TOGGLE, 1'b1, 8'h00, 1'b0);
        send_request(dbp_pkg::ACT_TOGGLE, 1'b1, 8'h00, 1'b0);
        send_request(dbp_pkg::ACT_TICK,   1'b0, 8'h00, 1'b0);
        send_request(dbp_pkg::ACT_SAMPLE, 1'b0, 8'hFE, 1'b1);
        send_request(dbp_pkg::ACT_SAMPLE, 1'b0, 8'hFE, 1'b1);  // input 1 falls
        send_request(dbp_pkg::ACT_TICK,   1'b0, 8'h00, 1'b0);
        send_request(dbp_pkg::ACT_SAMPLE, 1'b0, 8'hFF, 1'b1);
        send_request(dbp_pkg::ACT_SAMPLE, 1'b0, 8'hFF, 1'b1);  // input 0 falls
        send_request(dbp_pkg::ACT_SAMPLE, 1'b0, 8'h02, 1'b1);
        send_request(dbp_pkg::ACT_SAMPLE, 1'b0, 8'h02, 1'b1);  // input 0 rises onto a latch
        drain();

        // Zero pulse and latch lengths release in the same request
        apply_settings(1'b0, 16'd0, 24'd0, 1'b1, 3'd0, 3'd1);
        send_request(dbp_pkg::ACT_PULSE,  1'b0, 8'h00, 1'b0);
        send_request(dbp_pkg::ACT_TOGGLE, 1'b1, 8'h00, 1'b0);
        send_request(dbp_pkg::ACT_SAMPLE, 1'b0, 8'h03, 1'b1);
        send_request(dbp_pkg::ACT_SAMPLE, 1'b0, 8'h00, 1'b1);
        send_request(dbp_pkg::ACT_SAMPLE, 1'b0, 8'h00, 1'b1);
    endtask

    // One random stimulus step: mostly well-formed repeated reads and tick runs,
    // with pulse/toggle requests and some single noisy reads.
    task automatic random_step();
        int pick;
        int n;
        logic [7:0] raw;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            repeat (n)
                send_request(dbp_pkg::ACT_TICK, 1'($urandom), 8'($urandom), 1'($urandom));
        end
        else if (pick < 60)
        begin
            raw = 8'($urandom);
            send_request(dbp_pkg::ACT_SAMPLE, 1'($urandom), raw, 1'b1);
            if ($urandom_range(3) == 0)
                send_request(dbp_pkg::ACT_SAMPLE, 1'($urandom), 8'($urandom), 1'b0);
            send_request(dbp_pkg::ACT_SAMPLE, 1'($urandom), raw, 1'b1);
        end
        else if (pick < 75)
            send_request(dbp_pkg::ACT_PULSE, 1'($urandom), 8'($urandom), 1'($urandom));
        else if (pick < 88)
            send_request(dbp_pkg::ACT_TOGGLE, 1'($urandom), 8'($urandom), 1'($urandom));
        else
            send_request(dbp_pkg::ACT_SAMPLE, 1'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // Settings for each phase: short lengths so deadlines expire often, the
    // zero and maximum lengths, reset values, and random mixes.
    task automatic setup_phase(int p);
        case (p)
            0:
            begin
                cfg_write(CFG_SPARE_LO, 24'($urandom));
                cfg_write(CFG_SPARE_HI, 24'($urandom));
                apply_settings(1'b0, 16'd5, 24'd9, 1'b1, 3'd0, 3'd1);
            end
            1: apply_settings(1'b1, 16'd1, 24'd1, 1'b0, 3'd7, 3'd7);
            2: apply_settings(1'b0, 16'd0, 24'd0, 1'b1, 3'd3, 3'd5);
            3: apply_settings(1'b1, 16'hFFFF, 24'hFFFFFF, 1'b1, 3'd6, 3'd2);
            4: apply_settings(1'b0, 16'd12, 24'd30, 1'b1, 3'd0, 3'd1);
            5: apply_settings(1'b0, dbp_pkg::PULSE_MS_DEFAULT, dbp_pkg::LATCH_MS_DEFAULT,
                              1'b1, 3'd0, 3'd1);
            6: apply_settings(1'b1, 16'($urandom_range(1, 40)), 24'($urandom_range(1, 60)),
                              1'b1, 3'($urandom), 3'($urandom));
            default:
                apply_settings(1'($urandom), 16'($urandom_range(0, 50)),
                               24'($urandom_range(0, 80)), 1'($urandom),
                               3'($urandom), 3'($urandom));
        endcase
        // rotate through: no idling, sender idle, receiver stall, both
        case (p % 4)
            0:
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            1:
            begin
                send_idle_pct = 56;
                stall_pct     = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct     = 56;
            end
            default:
            begin
                send_idle_pct = 18;
                stall_pct     = 18;
            end
        endcase
    endtask

    initial
    begin
        int phase_start;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            setup_phase(p);
            // no idling on either side, then a long result hold-off to back up the block
            if (p == 4)
                hold_request = 1'b1;
            phase_start = total_sent;
            while (total_sent - phase_start < PHASE_ITEMS)
                random_step();
        end
        drain();

        $display("Covered %0d requests: %0d ticks, %0d samples, %0d pulses, %0d latch toggles",
                 total_sent, kind_sent[dbp_pkg::ACT_TICK], kind_sent[dbp_pkg::ACT_SAMPLE],
                 kind_sent[dbp_pkg::ACT_PULSE], kind_sent[dbp_pkg::ACT_TOGGLE]);
        $display("Compared %0d results over %0d settings with idle, stall and long hold-off",
                 checked, PHASES + 2);
        if (mismatches == 0 && awaiting == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
